@@ rtl/core/routing_table_with_aging_core_assert.svh @@
// ----------------------------------------------------------------------------
// Routing table assertion macros
// Shared concurrent assertion forms for the routing table core.
// ----------------------------------------------------------------------------
`ifndef ROUTING_TABLE_WITH_AGING_CORE_ASSERT_SVH
`define ROUTING_TABLE_WITH_AGING_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define RTWA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define RTWA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/rtwa_pkg.sv @@
// ----------------------------------------------------------------------------
// Routing table package
// Opcodes, route word layout, controller states and constants.
// ----------------------------------------------------------------------------
`default_nettype none

package rtwa_pkg;

  localparam int DEFAULT_DEPTH = 16;

  localparam logic [15:0] NO_HOP   = 16'hFFFF;
  localparam logic [7:0]  ACT_FULL = 8'hFF;

  typedef enum logic [2:0] {
    OP_INSERT  = 3'd0,
    OP_DELETE  = 3'd1,
    OP_LOOKUP  = 3'd2,
    OP_REFRESH = 3'd3,
    OP_TICK    = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESP
  } state_t;

  // 64-bit route word, destination in the top bits
  typedef struct packed {
    logic [15:0] dest;
    logic [15:0] hop;
    logic [7:0]  rtt;
    logic [7:0]  ttl;
    logic [7:0]  act;
    logic [7:0]  spare;
  } route_t;

endpackage

`default_nettype wire

@@ rtl/core/routing_table_with_aging_core.sv @@
// ----------------------------------------------------------------------------
// Routing table with aging
// Insertion-ordered route store with lookup, delete/compact, refresh and tick.
// ----------------------------------------------------------------------------
// Insert and unused opcodes: done in the cycle after accept; busy holds off the next start until after done.
// Delete, lookup, refresh, tick: one pass over the n live routes through the single
// table memory (one read and one write per cycle); done follows in S_RESP once the scan ends.
// The receiver cannot stall: done is high for one cycle only.
// Reset clears the route count; table words are undefined until written, no clear pass.
`default_nettype none

module routing_table_with_aging_core #(
  parameter int TABLE_DEPTH = rtwa_pkg::DEFAULT_DEPTH,
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1),
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output      logic             busy,
  input  wire logic [2:0]       op,
  input  wire logic [15:0]      dest_addr,
  input  wire logic [15:0]      hop_addr,
  input  wire logic [7:0]       round_trip,
  input  wire logic [7:0]       live_time,
  input  wire logic [7:0]       activity_in,
  input  wire logic [7:0]       spare_in,
  output      logic             done,
  output      logic             found,
  output      logic [15:0]      hop_out,
  output      logic             accepted,
  output      logic [CNT_W-1:0] entry_count
);

  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);
  localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

  rtwa_pkg::state_t state, state_next;
  rtwa_pkg::op_t    op_q;
  logic [15:0]      dest_q;
  logic             found_q;
  logic [15:0]      hop_q;
  logic             accepted_q;
  logic [CNT_W-1:0] live_count;
  logic [CNT_W-1:0] rd_ptr;
  logic [CNT_W-1:0] wr_ptr;
  logic             rd_vld;
  logic [IDX_W-1:0] proc_idx;
  logic [63:0]      rd_data;

  logic [63:0]      mem [TABLE_DEPTH];

  logic             accept;
  logic             issue;
  logic             hit;
  logic             keep;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [63:0]      wr_data;
  rtwa_pkg::route_t rd_entry;
  rtwa_pkg::route_t upd_entry;
  rtwa_pkg::route_t new_entry;

  assign accept   = start && !busy;
  assign rd_entry = rtwa_pkg::route_t'(rd_data);
  assign hit      = rd_vld && (rd_entry.dest == dest_q);
  assign keep     = rd_vld && !hit && (op_q == rtwa_pkg::OP_DELETE);

  always_comb begin
    new_entry.dest  = dest_addr;
    new_entry.hop   = hop_addr;
    new_entry.rtt   = round_trip;
    new_entry.ttl   = live_time;
    new_entry.act   = activity_in;
    new_entry.spare = spare_in;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      rtwa_pkg::S_IDLE: begin
        if (accept) begin
          if (rtwa_pkg::op_t'(op) == rtwa_pkg::OP_DELETE ||
              rtwa_pkg::op_t'(op) == rtwa_pkg::OP_LOOKUP ||
              rtwa_pkg::op_t'(op) == rtwa_pkg::OP_REFRESH ||
              rtwa_pkg::op_t'(op) == rtwa_pkg::OP_TICK) begin
            state_next = rtwa_pkg::S_SCAN;
          end else begin
            state_next = rtwa_pkg::S_RESP;
          end
        end
      end
      rtwa_pkg::S_SCAN: begin
        if (!issue) begin
          state_next = rtwa_pkg::S_RESP;
        end
      end
      rtwa_pkg::S_RESP: begin
        state_next = rtwa_pkg::S_IDLE;
      end
      default: begin
        state_next = rtwa_pkg::S_IDLE;
      end
    endcase
  end

  // outputs and memory controls
  always_comb begin
    busy      = 1'b1;
    done      = 1'b0;
    issue     = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = proc_idx;
    upd_entry = rd_entry;
    wr_data   = rd_data;
    unique case (state)
      rtwa_pkg::S_IDLE: begin
        busy    = 1'b0;
        wr_en   = accept && (rtwa_pkg::op_t'(op) == rtwa_pkg::OP_INSERT) &&
                  (live_count < DEPTH_C);
        wr_addr = live_count[IDX_W-1:0];
        wr_data = new_entry;
      end
      rtwa_pkg::S_SCAN: begin
        issue = (rd_ptr < live_count);
        // writes land at or behind the entry in process, never ahead of the read
        case (op_q)
          rtwa_pkg::OP_REFRESH: begin
            upd_entry.act = rtwa_pkg::ACT_FULL;
            wr_en         = hit;
          end
          rtwa_pkg::OP_TICK: begin
            upd_entry.act = rd_entry.act - 8'd1;
            wr_en         = rd_vld;
          end
          rtwa_pkg::OP_DELETE: begin
            wr_en   = keep;
            wr_addr = wr_ptr[IDX_W-1:0];
          end
          default: begin
            wr_en = 1'b0;
          end
        endcase
        wr_data = upd_entry;
      end
      rtwa_pkg::S_RESP: begin
        done = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  assign found       = found_q;
  assign hop_out     = hop_q;
  assign accepted    = accepted_q;
  assign entry_count = live_count;

  // table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (issue) begin
      rd_data <= mem[rd_ptr[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= rtwa_pkg::S_IDLE;
      live_count <= '0;
      rd_vld     <= 1'b0;
      rd_ptr     <= '0;
      wr_ptr     <= '0;
    end else begin
      state  <= state_next;
      rd_vld <= issue;
      if (issue) begin
        proc_idx <= rd_ptr[IDX_W-1:0];
        rd_ptr   <= rd_ptr + ONE_C;
      end
      if (accept) begin
        op_q       <= rtwa_pkg::op_t'(op);
        dest_q     <= dest_addr;
        found_q    <= 1'b0;
        hop_q      <= rtwa_pkg::NO_HOP;
        accepted_q <= wr_en;
        rd_ptr     <= '0;
        wr_ptr     <= '0;
        if (wr_en) begin
          live_count <= live_count + ONE_C;
        end
      end
      if (state == rtwa_pkg::S_SCAN) begin
        // tick reports no match
        if (hit && !found_q && op_q != rtwa_pkg::OP_TICK) begin
          found_q <= 1'b1;
          hop_q   <= rd_entry.hop;
        end
        if (keep) begin
          wr_ptr <= wr_ptr + ONE_C;
        end
        if (!issue && op_q == rtwa_pkg::OP_DELETE) begin
          live_count <= wr_ptr + (keep ? ONE_C : '0);
        end
      end
    end
  end

`include "routing_table_with_aging_core_assert.svh"

  `RTWA_ASSERT_SAME(a_count_in_range, clk, rst, 1'b1, live_count <= DEPTH_C, "route count over depth")
  `RTWA_ASSERT_SAME(a_write_behind_read, clk, rst, wr_en && state == rtwa_pkg::S_SCAN, CNT_W'(wr_addr) < rd_ptr, "scan write ahead of read")
  `RTWA_ASSERT_NEXT(a_accept_busy, clk, rst, accept, busy, "accepted word did not raise busy")
  `RTWA_ASSERT_NEXT(a_done_single, clk, rst, done, !done && !busy, "result strobe longer than one cycle")

endmodule

`default_nettype wire
